// File: sv/tdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_pkg
// Types and constants shared by the tail-drop queue monitor and its channels.
// ----------------------------------------------------------------------------
package tdq_pkg;

  // Configuration register indexes.
  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t REG_MAX_QUEUE_SIZE = 2'd0;
  localparam cfg_addr_t REG_SERVICE_TIME   = 2'd1;

  localparam int CFG_DATA_WIDTH = 10;
  typedef logic [CFG_DATA_WIDTH-1:0] cfg_data_t;

  // Register widths and reset values.
  localparam int CAP_WIDTH = 7;
  localparam int SVC_WIDTH = 10;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd64;
  localparam logic [SVC_WIDTH-1:0] SVC_RESET = 10'd15;

  // Widths of the result fields.
  localparam int WAIT_WIDTH  = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int SUM_WIDTH   = 48;
  localparam int LEN_WIDTH   = 7;

  typedef struct packed {
    logic arrival;
    logic final_tick;
  } in_item_t;

  typedef struct packed {
    logic                   dropped_now;
    logic                   served_now;
    logic [WAIT_WIDTH-1:0]  wait_of_served;
    logic [LEN_WIDTH-1:0]   queue_length;
    logic [COUNT_WIDTH-1:0] served_total;
    logic [COUNT_WIDTH-1:0] dropped_total;
    logic [SUM_WIDTH-1:0]   wait_total;
    logic [SUM_WIDTH-1:0]   length_total;
    logic                   run_done;
  } out_item_t;

endpackage
`default_nettype wire

// File: sv/tdq_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tdq_cfg_if import tdq_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  cfg_data_t data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// File: sv/tdq_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_in_if
// Tick request channel: one arrival flag and one end-of-run flag per tick.
// ----------------------------------------------------------------------------
interface tdq_in_if import tdq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: sv/tdq_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_out_if
// Result channel: per-tick events and running totals.
// ----------------------------------------------------------------------------
interface tdq_out_if import tdq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: sv/tdq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdq_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/tail_drop_queue_service_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tail_drop_queue_service_monitor
// Tail-drop queue with a fixed service time, observed one tick per request.
// ----------------------------------------------------------------------------
// Usage: every request on the items channel is one simulated tick, carrying
// an arrival flag and a final_tick flag. The block answers each tick with one
// result on the results channel: the drop and service events of that tick,
// the wait of a served entry, the occupancy and the running totals.
// A valid result follows in the cycle after a request is accepted, and one
// request is accepted in every cycle while results are taken: a tick's work
// is one level of logic between the queue state and the result register,
// and the queue's arrival ticks live in a RAM read one entry ahead of the head.
// When the receiver stalls, the result register holds its result and one
// new request is still accepted on the cycle the result is taken.
// Reset (rst, synchronous) clears the queue, all totals and the tick counter
// and loads max_queue_size = 64 and service_time = 15; no request and no
// configuration write is taken while rst is high. A request with
// final_tick set clears the same state after its result is formed; the
// configuration registers keep their values. Configuration writes are accepted
// in every cycle outside reset and must only be made while no result is
// outstanding.
// ----------------------------------------------------------------------------
module tail_drop_queue_service_monitor import tdq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TICK_WIDTH  = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  tdq_cfg_if.sink   cfg,
  tdq_in_if.sink    items,
  tdq_out_if.source results
);

  // Queue index width, occupancy width, and a width that holds both the
  // occupancy and the capacity register for comparison.
  localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Configuration registers.
  logic [CAP_WIDTH-1:0] max_queue_size;
  logic [SVC_WIDTH-1:0] service_time;

  // Queue and statistics state.
  logic [IW-1:0]          head_index;
  logic [IW-1:0]          tail_index;
  logic [CW-1:0]          entry_count;
  logic [SVC_WIDTH-1:0]   head_service_count;
  logic [TICK_WIDTH-1:0]  tick_number;
  logic [TICK_WIDTH-1:0]  head_tick;
  logic [COUNT_WIDTH-1:0] served_sum;
  logic [COUNT_WIDTH-1:0] dropped_sum;
  logic [SUM_WIDTH-1:0]   wait_sum;
  logic [SUM_WIDTH-1:0]   length_sum;

  // Prefetch of the entry behind the head, with a bypass for a write that
  // hit the same slot in the cycle it was read.
  logic [TICK_WIDTH-1:0] ram_rdata;
  logic                  fwd_hit;
  logic [TICK_WIDTH-1:0] fwd_data;

  // Result register.
  logic      res_valid;
  out_item_t res;

  // Per-tick logic.
  logic                   accept;
  logic [CMPW-1:0]        cap;
  logic [SVC_WIDTH-1:0]   need;
  logic                   full;
  logic                   drop;
  logic                   enq;
  logic [CW-1:0]          count_a;
  logic [SVC_WIDTH-1:0]   svc_inc;
  logic                   serve;
  logic [TICK_WIDTH-1:0]  cur_head_tick;
  logic [TICK_WIDTH-1:0]  wait_t;
  logic [SUM_WIDTH-1:0]   wait_wide;
  logic [CW-1:0]          count_next;
  logic [TICK_WIDTH-1:0]  next_entry_tick;
  logic [TICK_WIDTH-1:0]  head_tick_next;
  logic [IW-1:0]          head_index_next;
  logic [IW-1:0]          tail_index_next;
  logic [SVC_WIDTH-1:0]   head_service_count_next;
  logic [COUNT_WIDTH-1:0] served_sum_next;
  logic [COUNT_WIDTH-1:0] dropped_sum_next;
  logic [SUM_WIDTH:0]     wait_add;
  logic [SUM_WIDTH:0]     length_add;
  logic [SUM_WIDTH-1:0]   wait_sum_next;
  logic [SUM_WIDTH-1:0]   length_sum_next;
  logic [IW-1:0]          head_d;
  logic [IW-1:0]          ram_raddr;
  logic                   ram_we;

  assign cfg.ready     = !rst;
  assign items.ready   = !rst && (!res_valid || results.ready);
  assign accept        = items.valid && items.ready;
  assign results.valid = res_valid;
  assign results.data  = res;

  always_comb begin
    // A capacity register above the queue depth acts as the depth, and a
    // service time of zero acts as one tick.
    cap = (CMPW'(max_queue_size) > CMPW'(QUEUE_DEPTH)) ? CMPW'(QUEUE_DEPTH)
                                                       : CMPW'(max_queue_size);
    need = (service_time == '0) ? SVC_WIDTH'(1) : service_time;

    full    = CMPW'(entry_count) >= cap;
    drop    = items.data.arrival && full;
    enq     = items.data.arrival && !full;
    count_a = entry_count + CW'(enq);

    svc_inc = head_service_count + 1'b1;
    serve   = (count_a != '0) && (svc_inc == need);

    // An empty queue that takes an arrival has it at the head right away.
    cur_head_tick = (entry_count == '0) ? tick_number : head_tick;
    wait_t        = tick_number - cur_head_tick;
    wait_wide     = SUM_WIDTH'(wait_t);

    count_next = count_a - CW'(serve);

    // The entry that becomes head after a departure is either the one
    // enqueued in this same tick or the prefetched one.
    next_entry_tick = fwd_hit ? fwd_data : ram_rdata;
    if (serve) begin
      head_tick_next = (enq && entry_count == CW'(1)) ? tick_number : next_entry_tick;
    end else if (enq && entry_count == '0) begin
      head_tick_next = tick_number;
    end else begin
      head_tick_next = head_tick;
    end

    head_index_next         = serve ? idx_inc(head_index) : head_index;
    tail_index_next         = enq ? idx_inc(tail_index) : tail_index;
    head_service_count_next = serve ? '0 : ((count_a != '0) ? svc_inc : head_service_count);

    served_sum_next  = (serve && !(&served_sum)) ? served_sum + 1'b1 : served_sum;
    dropped_sum_next = (drop && !(&dropped_sum)) ? dropped_sum + 1'b1 : dropped_sum;

    wait_add      = {1'b0, wait_sum} + (serve ? (SUM_WIDTH + 1)'(wait_t) : '0);
    wait_sum_next = wait_add[SUM_WIDTH] ? '1 : wait_add[SUM_WIDTH-1:0];

    length_add      = {1'b0, length_sum} + (SUM_WIDTH + 1)'(count_next);
    length_sum_next = length_add[SUM_WIDTH] ? '1 : length_add[SUM_WIDTH-1:0];

    // Head index after this cycle, and the read of the slot behind it.
    if (accept) begin
      head_d = items.data.final_tick ? '0 : head_index_next;
    end else begin
      head_d = head_index;
    end
    ram_raddr = idx_inc(head_d);
    ram_we    = accept && enq;
  end

  tdq_ram #(
    .WIDTH (TICK_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_ticks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_index),
    .wdata (tick_number),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_queue_size <= CAP_RESET;
      service_time   <= SVC_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.addr)
        REG_MAX_QUEUE_SIZE: max_queue_size <= cfg.data[CAP_WIDTH-1:0];
        REG_SERVICE_TIME:   service_time   <= cfg.data[SVC_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Queue state and running totals. A final tick clears them after its
  // result has been formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index         <= '0;
      tail_index         <= '0;
      entry_count        <= '0;
      head_service_count <= '0;
      tick_number        <= '0;
      served_sum         <= '0;
      dropped_sum        <= '0;
      wait_sum           <= '0;
      length_sum         <= '0;
    end else if (accept) begin
      if (items.data.final_tick) begin
        head_index         <= '0;
        tail_index         <= '0;
        entry_count        <= '0;
        head_service_count <= '0;
        tick_number        <= '0;
        served_sum         <= '0;
        dropped_sum        <= '0;
        wait_sum           <= '0;
        length_sum         <= '0;
      end else begin
        head_index         <= head_index_next;
        tail_index         <= tail_index_next;
        entry_count        <= count_next;
        head_service_count <= head_service_count_next;
        tick_number        <= tick_number + 1'b1;
        served_sum         <= served_sum_next;
        dropped_sum        <= dropped_sum_next;
        wait_sum           <= wait_sum_next;
        length_sum         <= length_sum_next;
      end
    end
  end

  // Payload-only registers: head arrival tick and the read bypass.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_tick <= head_tick_next;
    end
    fwd_hit  <= ram_we && (tail_index == ram_raddr);
    fwd_data <= tick_number;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (items.ready) begin
      res_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.dropped_now    <= drop;
      res.served_now     <= serve;
      res.wait_of_served <= !serve ? '0
                          : (wait_wide > SUM_WIDTH'(32'hFFFF_FFFF)) ? '1
                          : wait_wide[WAIT_WIDTH-1:0];
      res.queue_length   <= LEN_WIDTH'(count_next);
      res.served_total   <= served_sum_next;
      res.dropped_total  <= dropped_sum_next;
      res.wait_total     <= wait_sum_next;
      res.length_total   <= length_sum_next;
      res.run_done       <= items.data.final_tick;
    end
  end

`ifndef SYNTHESIS
  // The occupancy never exceeds the physical queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // The tail always sits the occupancy beyond the head, modulo the depth.
  a_tail_pos: assert property (@(posedge clk) disable iff (rst)
    int'(tail_index) ==
      (((int'(head_index) + int'(entry_count)) >= QUEUE_DEPTH)
        ? (int'(head_index) + int'(entry_count) - QUEUE_DEPTH)
        : (int'(head_index) + int'(entry_count))))
    else $error("tail index out of step with head and occupancy");

  // A final tick leaves an empty queue and cleared totals behind it.
  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && items.data.final_tick) |=>
      (entry_count == '0 && tick_number == '0 && served_sum == '0 && length_sum == '0))
    else $error("state not cleared after final tick");
`endif

endmodule
`default_nettype wire

// File: bench/tail_drop_queue_service_monitor_tb.sv
// ----------------------------------------------------------------------------
// tail_drop_queue_service_monitor_tb
// Self-checking bench for the tail-drop queue monitor. Every tick request is
// run through a local model of the queue, and the model's result is queued.
// Each result the block returns is compared field by field with the oldest
// queued one. A few short directed tests come first, among them a long
// receiver hold-off. Then come runs of random ticks under several capacity
// and service-time settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tail_drop_queue_service_monitor_tb;
  import tdq_pkg::*;

  // The queue depth the block is built with; capacities above it act as it.
  localparam int QUEUE_DEPTH    = 64;
  // Cycles with no accepted request on any channel before the run is failed.
  // The slowest legal stretch is the receiver hold-off.
  localparam int STALL_LIMIT    = 5000;
  localparam int HOLDOFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tdq_cfg_if cfg_bus ();
  tdq_in_if  item_bus ();
  tdq_out_if result_bus ();

  tail_drop_queue_service_monitor dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .items   (item_bus),
    .results (result_bus)
  );

  // --------------------------------------------------------------------------
  // Local model of the queue. It keeps its own copy of the registers and of
  // all queue state, and is stepped once per accepted tick request.
  // --------------------------------------------------------------------------
  logic [CAP_WIDTH-1:0]   cap_setting;
  logic [SVC_WIDTH-1:0]   svc_setting;
  logic [31:0]            enqueue_tick [QUEUE_DEPTH];
  logic [5:0]             head_ptr;
  logic [LEN_WIDTH-1:0]   occupancy;
  logic [SVC_WIDTH-1:0]   service_progress;
  logic [31:0]            tick_now;
  logic [COUNT_WIDTH-1:0] served_count;
  logic [COUNT_WIDTH-1:0] dropped_count;
  logic [SUM_WIDTH-1:0]   wait_sum;
  logic [SUM_WIDTH-1:0]   length_sum;

  // Results the block still owes, oldest first.
  out_item_t pending_tick_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int holdoff_request;
  int holdoff_left;
  int error_count;
  int stall_cycles;
  int ticks_sent;
  int results_checked;
  int drops_seen;
  int services_seen;
  int runs_closed;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc32(logic [COUNT_WIDTH-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  function automatic logic [SUM_WIDTH-1:0] sat_add48(logic [SUM_WIDTH-1:0] a,
                                                     logic [SUM_WIDTH-1:0] b);
    logic [SUM_WIDTH:0] s;
    s = a + b;
    return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
  endfunction

  // Everything a final tick or reset clears. The registers are kept, and the
  // stored arrival ticks need no clearing since only written slots are read.
  function automatic void clear_queue_state();
    head_ptr         = '0;
    occupancy        = '0;
    service_progress = '0;
    tick_now         = '0;
    served_count     = '0;
    dropped_count    = '0;
    wait_sum         = '0;
    length_sum       = '0;
  endfunction

  // One tick of the queue: the arrival is dropped or enqueued, then the head
  // gets one tick of service and may leave, then the occupancy is summed.
  function automatic out_item_t queue_tick_outcome(in_item_t req);
    out_item_t            res;
    logic [CAP_WIDTH-1:0] capacity;
    logic [SVC_WIDTH-1:0] need;
    logic [5:0]           slot;
    logic [31:0]          waited;
    res      = '0;
    capacity = (cap_setting > CAP_WIDTH'(QUEUE_DEPTH)) ? CAP_WIDTH'(QUEUE_DEPTH)
                                                       : cap_setting;
    // A service time of zero behaves as one tick of service.
    need     = (svc_setting == '0) ? SVC_WIDTH'(1) : svc_setting;

    if (req.arrival) begin
      if (occupancy >= capacity) begin
        res.dropped_now = 1'b1;
        dropped_count   = sat_inc32(dropped_count);
      end else begin
        slot               = head_ptr + occupancy[5:0];
        enqueue_tick[slot] = tick_now;
        occupancy          = occupancy + 1'b1;
      end
    end

    // The progress counter is 10 bits wide and wraps, which matters when the
    // service time is lowered while an entry is already part way through.
    if (occupancy != '0) begin
      service_progress = service_progress + 1'b1;
      if (service_progress == need) begin
        waited             = tick_now - enqueue_tick[head_ptr];
        res.served_now     = 1'b1;
        res.wait_of_served = waited;
        wait_sum           = sat_add48(wait_sum, SUM_WIDTH'(waited));
        served_count       = sat_inc32(served_count);
        head_ptr           = head_ptr + 1'b1;
        occupancy          = occupancy - 1'b1;
        service_progress   = '0;
      end
    end

    length_sum        = sat_add48(length_sum, SUM_WIDTH'(occupancy));
    res.queue_length  = occupancy;
    res.served_total  = served_count;
    res.dropped_total = dropped_count;
    res.wait_total    = wait_sum;
    res.length_total  = length_sum;
    res.run_done      = req.final_tick;
    tick_now          = tick_now + 1'b1;
    if (req.final_tick) clear_queue_state();
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driving. Inputs change on the falling edge and handshakes are
  // judged on the rising edge, so the block never sees a change near its
  // sampling edge and the bench never reads a value mid-update.
  // --------------------------------------------------------------------------

  // Offers one tick request, with a random gap first, and waits for it to be
  // taken. Valid is left high so back-to-back requests need no idle gap.
  task automatic send_tick(in_item_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid = 1'b0;
      @(negedge clk);
    end
    item_bus.valid = 1'b1;
    item_bus.data  = req;
    do @(posedge clk); while (!item_bus.ready);
    pending_tick_results.push_back(queue_tick_outcome(req));
    ticks_sent++;
  endtask

  // Drops valid and waits until every owed result has come back, then lets the
  // result register settle.
  task automatic wait_drained();
    @(negedge clk);
    item_bus.valid = 1'b0;
    while (pending_tick_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(cfg_addr_t idx, int value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.addr  = idx;
    cfg_bus.data  = cfg_data_t'(value);
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_MAX_QUEUE_SIZE: cap_setting = CAP_WIDTH'(value);
      REG_SERVICE_TIME:   svc_setting = SVC_WIDTH'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Registers may only change while no result is owed.
  task automatic set_config(int capacity, int service);
    wait_drained();
    write_register(REG_MAX_QUEUE_SIZE, capacity);
    write_register(REG_SERVICE_TIME, service);
  endtask

  task automatic tick(bit arrival, bit final_tick);
    in_item_t req;
    req.arrival    = arrival;
    req.final_tick = final_tick;
    send_tick(req);
  endtask

  // Picks a setting, leaning toward small capacities and short services so
  // that drops and departures both happen often, but reaching the extremes.
  task automatic random_config();
    int capacity;
    int service;
    case ($urandom_range(0, 7))
      0: capacity = 0;
      1: capacity = 1;
      2: capacity = 2;
      3: capacity = $urandom_range(3, 8);
      4: capacity = QUEUE_DEPTH;
      5: capacity = 127;
      6: capacity = $urandom_range(0, 127);
      default: capacity = $urandom_range(4, 16);
    endcase
    case ($urandom_range(0, 6))
      0: service = 0;
      1: service = 1;
      2: service = 2;
      3: service = $urandom_range(3, 6);
      4: service = 1023;
      5: service = $urandom_range(1, 1023);
      default: service = $urandom_range(7, 20);
    endcase
    set_config(capacity, service);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // Reset values: capacity 64 and a service time of 15 ticks.
  task automatic test_reset_defaults();
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b1);
  endtask

  // A capacity of zero drops every arrival, including one on a final tick.
  task automatic test_capacity_zero();
    set_config(0, 1);
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b0);
    tick(1'b1, 1'b1);
  endtask

  // A service time of zero serves each arrival in its own tick with no wait.
  task automatic test_service_time_zero();
    set_config(2, 0);
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b1, 1'b0);
    tick(1'b0, 1'b1);
  endtask

  // The largest capacity and the longest service time; nothing leaves.
  task automatic test_capacity_above_depth();
    set_config(127, 1023);
    repeat (4) tick(1'b1, 1'b0);
    tick(1'b0, 1'b1);
  endtask

  // A short queue that fills, drops, and drains with growing waits.
  task automatic test_wait_accumulation();
    set_config(3, 3);
    repeat (5) tick(1'b1, 1'b0);
    repeat (3) tick(1'b0, 1'b0);
    tick(1'b0, 1'b1);
  endtask

  // Arrivals on every tick with two ticks of service: the queue grows by one
  // entry every other tick until it holds the full depth, then drops. By then
  // the head has gone all the way round the store.
  task automatic test_queue_overflow();
    set_config(127, 2);
    repeat (140) tick(1'b1, 1'b0);
    tick(1'b0, 1'b1);
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // result register fills and the block holds its input back.
  task automatic test_receiver_holdoff();
    in_item_t req;
    set_config(8, 3);
    holdoff_request = HOLDOFF_CYCLES;
    for (int i = 0; i < 30; i++) begin
      req.arrival    = 1'($urandom_range(0, 1));
      req.final_tick = (i == 29);
      send_tick(req);
    end
  endtask

  // The sender stops mid-run until every result is back, then carries on.
  task automatic test_sender_pause();
    set_config(5, 2);
    repeat (20) tick(1'($urandom_range(0, 1)), 1'b0);
    wait_drained();
    repeat (19) tick(1'($urandom_range(0, 1)), 1'b0);
    tick(1'b1, 1'b1);
  endtask

  // Mostly whole runs ending in a final tick, with a random arrival rate per
  // run; some runs are long enough to wrap the store. The rest is noise:
  // short bursts with random flags, final ticks landing anywhere.
  task automatic run_random_phase(int tick_budget, int s_idle, int r_idle);
    int       sent;
    int       run_len;
    int       arrive_pct;
    in_item_t req;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    random_config();
    sent = 0;
    while (sent < tick_budget) begin
      if ($urandom_range(0, 5) == 0) random_config();
      if ($urandom_range(0, 6) != 0) begin
        run_len    = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 160)
                                                 : $urandom_range(3, 40);
        arrive_pct = $urandom_range(10, 95);
        for (int i = 0; i < run_len; i++) begin
          req.arrival    = ($urandom_range(0, 99) < arrive_pct);
          req.final_tick = (i == run_len - 1);
          send_tick(req);
        end
        sent += run_len;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          req = in_item_t'(2'($urandom_range(0, 3)));
          send_tick(req);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: outside reset and hold-off, ready is redrawn on every falling edge.
  // A hold-off request from a test is taken over here and counted down cycle by cycle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      result_bus.ready = 1'b0;
    end else if (holdoff_request != 0) begin
      holdoff_left     = holdoff_request - 1;
      holdoff_request  = 0;
      result_bus.ready = 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      result_bus.ready = 1'b0;
    end else begin
      result_bus.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, logic [SUM_WIDTH-1:0] want,
                             logic [SUM_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Every result taken is matched against the oldest owed one.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = result_bus.data;
      if (pending_tick_results.size() == 0) begin
        $error("result taken with no tick request outstanding");
        error_count++;
      end else begin
        want = pending_tick_results.pop_front();
        check_field("dropped_now", SUM_WIDTH'(want.dropped_now),
                    SUM_WIDTH'(got.dropped_now));
        check_field("served_now", SUM_WIDTH'(want.served_now),
                    SUM_WIDTH'(got.served_now));
        check_field("wait_of_served", SUM_WIDTH'(want.wait_of_served),
                    SUM_WIDTH'(got.wait_of_served));
        check_field("queue_length", SUM_WIDTH'(want.queue_length),
                    SUM_WIDTH'(got.queue_length));
        check_field("served_total", SUM_WIDTH'(want.served_total),
                    SUM_WIDTH'(got.served_total));
        check_field("dropped_total", SUM_WIDTH'(want.dropped_total),
                    SUM_WIDTH'(got.dropped_total));
        check_field("wait_total", want.wait_total, got.wait_total);
        check_field("length_total", want.length_total, got.length_total);
        check_field("run_done", SUM_WIDTH'(want.run_done),
                    SUM_WIDTH'(got.run_done));
        results_checked++;
        drops_seen    += int'(want.dropped_now);
        services_seen += int'(want.served_now);
        runs_closed   += int'(want.run_done);
      end
    end
  end

  // Watchdog: any accepted request on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $error("no request accepted for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    item_bus.valid   = 1'b0;
    item_bus.data    = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.addr     = REG_MAX_QUEUE_SIZE;
    cfg_bus.data     = '0;
    result_bus.ready = 1'b0;
    send_idle_pct    = 6;
    recv_idle_pct    = 73;
    holdoff_request  = 0;
    holdoff_left     = 0;
    error_count      = 0;
    stall_cycles     = 0;
    ticks_sent       = 0;
    results_checked  = 0;
    drops_seen       = 0;
    services_seen    = 0;
    runs_closed      = 0;
    cap_setting      = CAP_RESET;
    svc_setting      = SVC_RESET;
    clear_queue_state();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_capacity_zero();
    test_service_time_zero();
    test_capacity_above_depth();
    test_wait_accumulation();
    test_queue_overflow();
    test_receiver_holdoff();
    test_sender_pause();
    run_random_phase(120, 6, 73);
    run_random_phase(120, 73, 6);
    run_random_phase(120, 0, 0);
    wait_drained();

    $display("Run covered %0d ticks and %0d results: %0d drops, %0d departures, %0d runs.",
             ticks_sent, results_checked, drops_seen, services_seen, runs_closed);
    $display("Capacities 0 to 127 and service times 0 to 1023, with stalls on both sides.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tdq_pkg.sv
sv/tdq_cfg_if.sv
sv/tdq_in_if.sv
sv/tdq_out_if.sv
sv/tdq_ram.sv
sv/tail_drop_queue_service_monitor.sv
bench/tail_drop_queue_service_monitor_tb.sv
